### hdl/nvl_pkg.sv
// Shared constants and types for the vector normalize/length core.
// Used by nvl_sqrt, nvl_div_lane and vector3_normalize_length_core.
package nvl_pkg;

	// Fraction bits of the fixed-point format
	localparam int FRAC_BITS = 16;

	localparam int VEC_W  = 32;
	localparam int UNIT_W = 18;
	localparam int MAG_W  = 32;
	localparam int SUM_W  = 2 * VEC_W;

	// Square root: one root bit per stage
	localparam int SQ_STAGES = SUM_W / 2;
	localparam int SQ_RW     = MAG_W + 4;

	// Division lanes: one quotient bit per stage
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int DIV_RW = MAG_W + 2;

	// Width used to negate the quotient before truncation to UNIT_W
	localparam int EXT_W = (QUO_W + 1 > UNIT_W) ? QUO_W + 1 : UNIT_W;

	// Per-word data riding alongside the square root
	typedef struct packed {
		logic [2:0]       neg;
		logic [VEC_W-1:0] ax;
		logic [VEC_W-1:0] ay;
		logic [VEC_W-1:0] az;
	} sq_side_t;

	// Per-word data riding alongside the division lanes
	typedef struct packed {
		logic [2:0]       neg;
		logic             zero;
		logic [MAG_W-1:0] mag;
	} div_side_t;

endpackage

### hdl/nvl_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on nvl_pkg.
module nvl_sqrt (
	input  logic                                clk,
	input  logic [nvl_pkg::SUM_W-1:0]           rad_in,
	input  nvl_pkg::sq_side_t                   side_in,
	output logic [nvl_pkg::MAG_W-1:0]           root_out,
	output nvl_pkg::sq_side_t                   side_out
);
	import nvl_pkg::*;

	logic [SUM_W-1:0] rad_s  [SQ_STAGES];
	logic [SQ_RW-1:0] rem_s  [SQ_STAGES];
	logic [MAG_W-1:0] root_s [SQ_STAGES];
	sq_side_t         side_s [SQ_STAGES];

	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
		logic [SUM_W-1:0] rad;
		logic [SQ_RW-1:0] rem;
		logic [MAG_W-1:0] root;
		sq_side_t         side;
		logic [SQ_RW-1:0] shifted;
		logic [SQ_RW-1:0] trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rad  = rad_in;
			assign rem  = '0;
			assign root = '0;
			assign side = side_in;
		end else begin : g_rest
			assign rad  = rad_s[i-1];
			assign rem  = rem_s[i-1];
			assign root = root_s[i-1];
			assign side = side_s[i-1];
		end

		// bring down two radicand bits, try root*4+1
		assign shifted = {rem[SQ_RW-3:0], rad[SUM_W-1 -: 2]};
		assign trial   = SQ_RW'({root, 2'b01});
		assign ge      = shifted >= trial;

		always_ff @(posedge clk) begin
			rad_s[i]  <= {rad[SUM_W-3:0], 2'b00};
			rem_s[i]  <= ge ? shifted - trial : shifted;
			root_s[i] <= {root[MAG_W-2:0], ge};
			side_s[i] <= side;
		end
	end

	assign root_out = root_s[SQ_STAGES-1];
	assign side_out = side_s[SQ_STAGES-1];

endmodule

### hdl/nvl_div_lane.sv
// One division lane: (num << FRAC_BITS) / den, one quotient bit per stage.
// Depends on nvl_pkg; requires num <= den.
module nvl_div_lane (
	input  logic                          clk,
	input  logic [nvl_pkg::VEC_W-1:0]     num,
	input  logic [nvl_pkg::MAG_W-1:0]     den,
	output logic [nvl_pkg::QUO_W-1:0]     quo
);
	import nvl_pkg::*;

	logic [DIV_RW-1:0] rem_s [QUO_W];
	logic [MAG_W-1:0]  den_s [QUO_W];
	logic [QUO_W-1:0]  quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DIV_RW-1:0] rem;
		logic [MAG_W-1:0]  d;
		logic [QUO_W-1:0]  q;
		logic [DIV_RW-1:0] sh;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem = DIV_RW'(num);
			assign d   = den;
			assign q   = '0;
			assign sh  = rem;
		end else begin : g_rest
			assign rem = rem_s[k-1];
			assign d   = den_s[k-1];
			assign q   = quo_s[k-1];
			assign sh  = {rem[DIV_RW-2:0], 1'b0};
		end

		// restoring step
		assign ge = sh >= DIV_RW'(d);

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? sh - DIV_RW'(d) : sh;
			den_s[k] <= d;
			quo_s[k] <= {q[QUO_W-2:0], ge};
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

### hdl/vector3_normalize_length_core.sv
// Vector normalize/length core: top level with magnitude, square and merge stages.
// Depends on nvl_pkg, nvl_sqrt and nvl_div_lane.
//
// Usage: drive vec_x, vec_y, vec_z (signed Q16.16) and pulse start for one
// cycle per word. busy is never raised, so a word is taken on every cycle
// that start is high: one word per clock, sustained.
// Results appear on unit_x/unit_y/unit_z (signed Q1.16), magnitude
// (unsigned Q16.16, floor of the length) and is_zero, qualified by a
// one-cycle done strobe, in the same order as the words went in.
// The pipeline runs through registered stages for absolute value, squares
// and sum, then the square-root pipeline with one root bit per stage, the
// three parallel division lanes with one quotient bit per stage, and a
// final sign/zero merge register.
// Reset clears only the valid pipeline; no words are in flight afterward.
// The receiver cannot stall; done is a strobe and results must be taken
// on the cycle they are shown.
module vector3_normalize_length_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [nvl_pkg::VEC_W-1:0]     vec_x,
	input  logic signed [nvl_pkg::VEC_W-1:0]     vec_y,
	input  logic signed [nvl_pkg::VEC_W-1:0]     vec_z,
	output logic                                 done,
	output logic signed [nvl_pkg::UNIT_W-1:0]    unit_x,
	output logic signed [nvl_pkg::UNIT_W-1:0]    unit_y,
	output logic signed [nvl_pkg::UNIT_W-1:0]    unit_z,
	output logic        [nvl_pkg::MAG_W-1:0]     magnitude,
	output logic                                 is_zero
);
	import nvl_pkg::*;

	localparam int LAT = 3 + SQ_STAGES + QUO_W + 1;
	localparam int VLD_W = LAT - 1;

	logic             acc;
	logic [VLD_W-1:0] vld_q;
	sq_side_t         side_s1, side_s2, side_s3, sq_side;
	logic [SUM_W-1:0] sqx_s2, sqy_s2, sqz_s2, sum_s3;
	logic [MAG_W-1:0] root;
	div_side_t        dside_s [QUO_W];
	logic [QUO_W-1:0] qx, qy, qz;
	logic             done_q, zero_q;
	logic [UNIT_W-1:0] ux_q, uy_q, uz_q;
	logic [MAG_W-1:0] mag_q;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	function automatic logic [VEC_W-1:0] abs_of(input logic [VEC_W-1:0] v);
		abs_of = v[VEC_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [UNIT_W-1:0] signed_unit(input logic [QUO_W-1:0] q,
		input logic neg);
		logic [EXT_W-1:0] e;
		e = EXT_W'(q);
		if (neg)
			e = ~e + 1'b1;
		signed_unit = e[UNIT_W-1:0];
	endfunction

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[VLD_W-2:0], acc};
			done_q <= vld_q[VLD_W-1];
		end
	end

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		side_s1.neg <= {vec_z[VEC_W-1], vec_y[VEC_W-1], vec_x[VEC_W-1]};
		side_s1.ax  <= abs_of(vec_x);
		side_s1.ay  <= abs_of(vec_y);
		side_s1.az  <= abs_of(vec_z);
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		sqx_s2  <= SUM_W'(side_s1.ax) * SUM_W'(side_s1.ax);
		sqy_s2  <= SUM_W'(side_s1.ay) * SUM_W'(side_s1.ay);
		sqz_s2  <= SUM_W'(side_s1.az) * SUM_W'(side_s1.az);
		side_s2 <= side_s1;
	end

	// stage 3: sum of squares, fits in 64 bits
	always_ff @(posedge clk) begin
		sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
		side_s3 <= side_s2;
	end

	nvl_sqrt u_sqrt (
		.clk      (clk),
		.rad_in   (sum_s3),
		.side_in  (side_s3),
		.root_out (root),
		.side_out (sq_side)
	);

	// three lanes, one per component
	nvl_div_lane u_lane_x (.clk(clk), .num(sq_side.ax), .den(root), .quo(qx));
	nvl_div_lane u_lane_y (.clk(clk), .num(sq_side.ay), .den(root), .quo(qy));
	nvl_div_lane u_lane_z (.clk(clk), .num(sq_side.az), .den(root), .quo(qz));

	// length, signs and zero flag follow the lanes
	always_ff @(posedge clk) begin
		dside_s[0].neg  <= sq_side.neg;
		dside_s[0].zero <= (root == '0);
		dside_s[0].mag  <= root;
		for (int i = 1; i < QUO_W; i++)
			dside_s[i] <= dside_s[i-1];
	end

	// merge: apply signs, force zero vector result
	always_ff @(posedge clk) begin
		if (dside_s[QUO_W-1].zero) begin
			ux_q <= '0;
			uy_q <= '0;
			uz_q <= '0;
		end else begin
			ux_q <= signed_unit(qx, dside_s[QUO_W-1].neg[0]);
			uy_q <= signed_unit(qy, dside_s[QUO_W-1].neg[1]);
			uz_q <= signed_unit(qz, dside_s[QUO_W-1].neg[2]);
		end
		mag_q  <= dside_s[QUO_W-1].mag;
		zero_q <= dside_s[QUO_W-1].zero;
	end

	assign done      = done_q;
	assign unit_x    = ux_q;
	assign unit_y    = uy_q;
	assign unit_z    = uz_q;
	assign magnitude = mag_q;
	assign is_zero   = zero_q;

	// each accepted word is followed by a done strobe at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("result strobe missing after pipeline latency");

	// no result strobe without a matching accepted word at the head of the pipeline
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result strobe without an accepted word");

	// zero flag agrees with the length
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_zero == (magnitude == '0)))
		else $error("zero flag disagrees with magnitude");

	// zero vector gives a zero unit vector
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_zero) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
		else $error("zero vector with nonzero unit components");

endmodule
